/* rtl/rkc_pkg.sv */
// rkc_pkg: item types, operation and register codes, reset values and fsm states
// for the rgb kernel convolution core. no dependencies.
package rkc_pkg;

    localparam int PIX_W = 24;
    localparam int CH_W  = 8;
    localparam logic [CH_W-1:0] CH_MAX = 8'd255;

    typedef logic [PIX_W-1:0] t_pixel;

    typedef struct packed {
        logic [1:0]         operation;
        logic [7:0]         in_red;
        logic [7:0]         in_green;
        logic [7:0]         in_blue;
        logic [5:0]         coef_index;
        logic signed [15:0] coef_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       run_last;
        logic       frame_done;
    } t_out_item;

    // operation codes
    localparam logic [1:0] OP_PIXEL  = 2'd0;
    localparam logic [1:0] OP_DRAIN  = 2'd1;
    localparam logic [1:0] OP_COEF   = 2'd2;
    localparam logic [1:0] OP_IGNORE = 2'd3;

    // register indexes
    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_KERNEL_RADIUS = 2'd1;
    localparam logic [1:0] REG_NORM_RECIP    = 2'd2;
    localparam logic [1:0] REG_NORM_ENABLE   = 2'd3;

    localparam logic [11:0] RST_IMAGE_WIDTH   = 12'd640;
    localparam logic [1:0]  RST_KERNEL_RADIUS = 2'd1;
    localparam logic [23:0] RST_NORM_RECIP    = 24'd7282;
    localparam logic        RST_NORM_ENABLE   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LINE,
        ST_DEC,
        ST_MAC,
        ST_MACL,
        ST_NORM,
        ST_NORM2,
        ST_OUT,
        ST_SHIFT,
        ST_FIN
    } t_state;

endpackage

/* rtl/rkc_if.sv */
// rkc_in_if / rkc_out_if: valid-ready channels for input and result items
// depends on rkc_pkg for the payload types
interface rkc_in_if;
    import rkc_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rkc_out_if;
    import rkc_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/rkc_scale.sv */
// rkc_scale: one channel's normalization by the reciprocal (or pass-through when disabled) and clamp to 0..255
// two partial products registered, sum and clamp after; uses rkc_pkg
module rkc_scale #(
    parameter int ACC_W = 31
) (
    input  logic                    i_clk,
    input  logic signed [ACC_W-1:0] i_acc,
    input  logic signed [23:0]      i_recip,
    input  logic                    i_norm_en,
    output logic [7:0]              o_val
);
    import rkc_pkg::*;

    localparam int HW = ACC_W - 16;
    localparam int FW = ACC_W + 25;

    logic signed [40:0]      r_p_lo;
    logic signed [HW+23:0]   r_p_hi;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_en;
    logic signed [FW-1:0]    s_full;
    logic signed [FW-1:0]    s_hi_ext;
    logic                    s_neg;
    logic                    s_sat;
    logic [7:0]              s_int;

    always_ff @(posedge i_clk) begin
        r_p_lo <= $signed({1'b0, i_acc[15:0]}) * i_recip;
        r_p_hi <= $signed(i_acc[ACC_W-1:16]) * i_recip;
        r_acc  <= i_acc;
        r_en   <= i_norm_en;
    end

    always_comb begin
        s_hi_ext = FW'(r_p_hi);
        s_full   = (s_hi_ext <<< 16) + FW'(r_p_lo);
        if (r_en) begin
            s_neg = s_full[FW-1];
            s_sat = |s_full[FW-1:32];
            s_int = s_full[31:24];
        end else begin
            s_neg = r_acc[ACC_W-1];
            s_sat = |r_acc[ACC_W-1:16];
            s_int = r_acc[15:8];
        end
        if (s_neg) begin
            o_val = '0;
        end else if (s_sat) begin
            o_val = CH_MAX;
        end else begin
            o_val = s_int;
        end
    end

endmodule

/* rtl/rgb_kernel_convolution_core.sv */
// rgb_kernel_convolution_core: odd square kernel convolution of rgb pixels, edge clamp
// one item at a time: a pixel or drain item gives up to r+1 results, each a mac over
// the (2r+1)^2 taps, with a right-edge shift between them; coef and ignored items are taken in idle
// line buffers sit in one synchronous memory read at accept and written back once
// reset (sync, active low) clears counters, state, window and configuration registers; no clearing pass
// depends on rkc_pkg, rkc_if, rkc_scale
module rgb_kernel_convolution_core #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_RADIUS = 3,
    parameter int COEF_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rkc_in_if.sink      i_in,
    rkc_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rkc_pkg::*;

    localparam int KSIDE = 2 * MAX_RADIUS + 1;
    localparam int NTAP  = KSIDE * KSIDE;
    localparam int NL    = 2 * MAX_RADIUS;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int KW    = $clog2(KSIDE);
    localparam int TAW   = $clog2(NTAP);
    localparam int CB    = (COEF_BITS < 16) ? COEF_BITS : 16;
    localparam int ACC_W = 9 + CB + TAW;
    localparam int PW    = 9 + CB;

    // configuration
    logic [11:0]        r_img_w;
    logic [1:0]         r_radius;
    logic signed [23:0] r_recip;
    logic               r_norm_en;
    logic               s_cfg_wr;

    // control
    t_state         r_state, n_state;
    logic [CW-1:0]  r_col;
    logic [12:0]    r_row;
    logic [RW-1:0]  r_seen;
    logic           r_draining;
    logic [RW-1:0]  r_t;
    logic [KW-1:0]  r_p, r_q;
    logic           r_pend;

    // payload
    logic [1:0]          r_op;
    t_pixel              r_pix;
    t_pixel              r_win [NTAP];
    logic [PIX_W*NL-1:0] r_rd;
    logic [PIX_W-1:0]    r_tap;
    logic signed [CB-1:0] r_coef;
    logic signed [ACC_W-1:0] r_acc [3];
    t_out_item           r_out;

    logic [PIX_W*NL-1:0] line_mem [MAX_WIDTH];
    logic [CB-1:0]       coef_mem [NTAP];

    logic [WW-1:0]   s_w;
    logic [RW-1:0]   s_r;
    logic [KW-1:0]   s_r2;
    logic [CW-1:0]   s_c;
    logic            s_last;
    logic            s_accept;
    logic            s_go;
    logic            s_drain_start;
    logic            s_coef_we;
    logic            s_active;
    logic            s_emit;
    logic            s_more;
    logic            s_mac_end;
    logic            s_run_last;
    logic            s_frame;
    logic [TAW-1:0]  s_tap_a;
    t_pixel          s_rd_line [KSIDE];
    t_pixel          s_top;
    t_pixel          s_v [KSIDE];
    logic [PIX_W*NL-1:0] s_wdata;
    logic [7:0]      s_ch [3];
    logic signed [PW-1:0] s_prod [3];

    // control outputs of the fsm
    logic s_in_ready;
    logic s_out_valid;
    logic s_line_we;
    logic s_fill;
    logic s_shift_en;

    // ---------------- configuration port ----------------
    assign s_cfg_wr = psel && penable && pwrite;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w   <= RST_IMAGE_WIDTH;
            r_radius  <= RST_KERNEL_RADIUS;
            r_recip   <= RST_NORM_RECIP;
            r_norm_en <= RST_NORM_ENABLE;
        end else if (s_cfg_wr) begin
            unique case (paddr[3:2])
                REG_IMAGE_WIDTH:   r_img_w   <= pwdata[11:0];
                REG_KERNEL_RADIUS: r_radius  <= pwdata[1:0];
                REG_NORM_RECIP:    r_recip   <= pwdata[23:0];
                REG_NORM_ENABLE:   r_norm_en <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_IMAGE_WIDTH:   prdata = {20'd0, r_img_w};
            REG_KERNEL_RADIUS: prdata = {30'd0, r_radius};
            REG_NORM_RECIP:    prdata = {8'd0, r_recip};
            REG_NORM_ENABLE:   prdata = {31'd0, r_norm_en};
            default:           prdata = '0;
        endcase
    end

    // ---------------- effective geometry ----------------
    always_comb begin
        if ({20'd0, r_img_w} > 32'(MAX_WIDTH)) begin
            s_w = WW'(MAX_WIDTH);
        end else if (r_img_w == '0) begin
            s_w = WW'(1);
        end else begin
            s_w = WW'(r_img_w);
        end
        if ({30'd0, r_radius} > 32'(MAX_RADIUS)) begin
            s_r = RW'(MAX_RADIUS);
        end else begin
            s_r = RW'(r_radius);
        end
        s_r2 = KW'(32'(s_r) * 2);
        // column past a shrunk width acts as the last column
        if (WW'(r_col) >= s_w) begin
            s_c = CW'(s_w - WW'(1));
        end else begin
            s_c = r_col;
        end
        s_last = (WW'(s_c) == (s_w - WW'(1)));
    end

    assign s_accept      = i_in.valid && s_in_ready;
    assign s_drain_start = (r_col == '0) && (r_row != '0) && (s_r != '0);
    assign s_go = s_accept &&
                  (((i_in.data.operation == OP_PIXEL) && !r_draining) ||
                   ((i_in.data.operation == OP_DRAIN) && (r_draining || s_drain_start)));
    assign s_coef_we = s_accept && (i_in.data.operation == OP_COEF) &&
                       ({26'd0, i_in.data.coef_index} < 32'(NTAP));

    assign s_active   = {19'd0, r_row} >= 32'(s_r);
    assign s_emit     = s_active && ((32'(s_c) + 32'(r_t)) >= 32'(s_r));
    assign s_more     = s_last && (r_t < s_r);
    assign s_mac_end  = (r_p == s_r2) && (r_q == s_r2);
    assign s_run_last = !s_more;
    assign s_frame    = s_run_last && s_last && r_draining &&
                        ((32'(r_seen) + 32'd1) >= 32'(s_r));
    assign s_tap_a    = TAW'(32'(r_p) * KSIDE + 32'(r_q));

    // ---------------- fsm ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (s_go) n_state = ST_LINE;
            ST_LINE:  n_state = ST_DEC;
            ST_DEC: begin
                if (s_emit) begin
                    n_state = ST_MAC;
                end else if (s_more) begin
                    n_state = ST_SHIFT;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_MAC:   if (s_mac_end) n_state = ST_MACL;
            ST_MACL:  n_state = ST_NORM;
            ST_NORM:  n_state = ST_NORM2;
            ST_NORM2: n_state = ST_OUT;
            ST_OUT: begin
                if (o_out.ready) begin
                    n_state = s_more ? ST_SHIFT : ST_FIN;
                end
            end
            ST_SHIFT: n_state = ST_DEC;
            ST_FIN:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_in_ready  = (r_state == ST_IDLE);
        s_out_valid = (r_state == ST_OUT);
        s_line_we   = (r_state == ST_LINE);
        s_fill      = (r_state == ST_LINE) && (s_c == '0);
        s_shift_en  = ((r_state == ST_LINE) && (s_c != '0)) || (r_state == ST_SHIFT);
    end

    assign i_in.ready  = s_in_ready;
    assign o_out.valid = s_out_valid;
    assign o_out.data  = r_out;

    // ---------------- line buffer memory ----------------
    always_comb begin
        for (int j = 0; j < KSIDE; j++) begin
            if (j < NL) begin
                s_rd_line[j] = r_rd[j*PIX_W +: PIX_W];
            end else begin
                s_rd_line[j] = '0;
            end
        end
    end

    // new column of taps: from the line buffers and the new pixel, or the window's right edge
    always_comb begin
        s_top = r_pix;
        if (r_op != OP_PIXEL) begin
            for (int j = 0; j < NL; j++) begin
                if (32'(j) + 32'd1 == 32'(s_r2)) s_top = s_rd_line[j];
            end
        end
        for (int k = 0; k < KSIDE; k++) begin
            s_v[k] = '0;
            if (r_state == ST_SHIFT) begin
                for (int m = 0; m < KSIDE; m++) begin
                    if (32'(m) == 32'(s_r2)) s_v[k] = r_win[k*KSIDE + m];
                end
            end else if (32'(k) == 32'(s_r2)) begin
                s_v[k] = s_top;
            end else if (32'(k) < 32'(s_r2)) begin
                s_v[k] = (r_row == '0) ? s_top : s_rd_line[k];
            end
        end
        for (int j = 0; j < NL; j++) begin
            if (32'(j) < 32'(s_r2)) begin
                s_wdata[j*PIX_W +: PIX_W] = s_v[j+1];
            end else begin
                s_wdata[j*PIX_W +: PIX_W] = s_rd_line[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_line_we) line_mem[s_c] <= s_wdata;
        r_rd <= line_mem[s_c];
    end

    // ---------------- coefficient memory ----------------
    always_ff @(posedge i_clk) begin
        if (s_coef_we) begin
            coef_mem[TAW'(i_in.data.coef_index)] <= i_in.data.coef_value[CB-1:0];
        end
        r_coef <= coef_mem[s_tap_a];
    end

    // ---------------- window ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NTAP; i++) r_win[i] <= '0;
        end else begin
            for (int k = 0; k < KSIDE; k++) begin
                for (int m = 0; m < KSIDE; m++) begin
                    if ((32'(k) <= 32'(s_r2)) && (32'(m) <= 32'(s_r2))) begin
                        if (s_fill) begin
                            r_win[k*KSIDE + m] <= s_v[k];
                        end else if (s_shift_en) begin
                            if ((m < KSIDE - 1) && (32'(m) < 32'(s_r2))) begin
                                r_win[k*KSIDE + m] <= r_win[k*KSIDE + m + 1];
                            end else begin
                                r_win[k*KSIDE + m] <= s_v[k];
                            end
                        end
                    end
                end
            end
        end
    end

    // ---------------- mac over the taps ----------------
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            s_prod[ch] = $signed({1'b0, r_tap[(2-ch)*CH_W +: CH_W]}) * r_coef;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op  <= i_in.data.operation;
            r_pix <= {i_in.data.in_red, i_in.data.in_green, i_in.data.in_blue};
        end
        r_tap <= r_win[s_tap_a];
        for (int ch = 0; ch < 3; ch++) begin
            if (r_state == ST_DEC) begin
                r_acc[ch] <= '0;
            end else if (r_pend) begin
                r_acc[ch] <= r_acc[ch] + ACC_W'(s_prod[ch]);
            end
        end
        if (r_state == ST_NORM2) begin
            r_out.out_red    <= s_ch[0];
            r_out.out_green  <= s_ch[1];
            r_out.out_blue   <= s_ch[2];
            r_out.run_last   <= s_run_last;
            r_out.frame_done <= s_frame;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_scale
        rkc_scale #(
            .ACC_W (ACC_W)
        ) u_scale (
            .i_clk     (i_clk),
            .i_acc     (r_acc[g]),
            .i_recip   (r_recip),
            .i_norm_en (r_norm_en),
            .o_val     (s_ch[g])
        );
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_col      <= '0;
            r_row      <= '0;
            r_seen     <= '0;
            r_draining <= 1'b0;
            r_t        <= '0;
            r_p        <= '0;
            r_q        <= '0;
            r_pend     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= (r_state == ST_MAC);
            if (s_go && (i_in.data.operation == OP_DRAIN)) r_draining <= 1'b1;
            case (r_state)
                ST_LINE:  r_t <= '0;
                ST_SHIFT: r_t <= r_t + RW'(1);
                ST_DEC: begin
                    r_p <= '0;
                    r_q <= '0;
                end
                ST_MAC: begin
                    if (r_q == s_r2) begin
                        r_q <= '0;
                        r_p <= r_p + KW'(1);
                    end else begin
                        r_q <= r_q + KW'(1);
                    end
                end
                ST_FIN: begin
                    if (s_last) begin
                        r_col <= '0;
                        if (r_draining && ((32'(r_seen) + 32'd1) >= 32'(s_r))) begin
                            // drain complete: frame ends
                            r_row      <= '0;
                            r_seen     <= '0;
                            r_draining <= 1'b0;
                        end else begin
                            if (r_row != 13'h1FFF) r_row <= r_row + 13'd1;
                            if (r_draining) r_seen <= r_seen + RW'(1);
                        end
                    end else begin
                        r_col <= s_c + CW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
